### rtl/itp_pkg.sv
// Shared constants and helpers for the infix to postfix converter.
package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CHAR_W      = 8;

    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_MUL   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DIV   = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_POW   = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;

    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // precedence rank: unknown ranks below all real operators
    localparam logic [1:0] PREC_NONE = 2'd0;
    localparam logic [1:0] PREC_ADD  = 2'd1;
    localparam logic [1:0] PREC_MUL  = 2'd2;
    localparam logic [1:0] PREC_POW  = 2'd3;

    function automatic logic [1:0] prec_of(input logic [CHAR_W-1:0] c);
        logic [1:0] p;
        case (c)
            CH_PLUS, CH_MINUS: p = PREC_ADD;
            CH_MUL, CH_DIV:    p = PREC_MUL;
            CH_POW:            p = PREC_POW;
            default:           p = PREC_NONE;
        endcase
        return p;
    endfunction

    function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
    endfunction

endpackage

### rtl/itp_if.sv
// Valid/ready channel interfaces for input and result words.
interface itp_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] character;

    modport source (output valid, command, character, input ready);
    modport sink   (input valid, command, character, output ready);
endinterface

interface itp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       end_marker;
    logic       overflowed;
    logic       unmatched_close;
    logic       last;

    modport source (output valid, out_char, end_marker, overflowed, unmatched_close, last,
                    input ready);
    modport sink   (input valid, out_char, end_marker, overflowed, unmatched_close, last,
                    output ready);
endinterface

### rtl/itp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module itp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/infix_to_postfix_converter.sv
// Top level: shunting-yard infix to postfix converter with a RAM operator stack.
//
// Input channel i_in carries one word per character (command = 0) or an end
// command (command = 1). Output channel o_out carries postfix characters; the
// end command closes with a terminator word (end_marker = 1, out_char = 0)
// that reports the sticky overflow and unmatched-close flags and clears them.
// last marks the final result word caused by each input word.
// Sequence: '(' is pushed straight from S_IDLE on acceptance. A letter or
// digit goes to S_FIN, where it is written to the output register. ')' and
// operators loop through S_RD and S_EV while top entries are popped; S_EV
// then pushes the operator or drops the matching '(' and moves to S_FIN. An
// end command pops every entry and emits the terminator in S_FIN. Each pop
// is paced by the stack RAM: S_RD presents the top address, S_EV uses its data.
// A result word sits in the output register until taken; a stalled receiver
// holds the block at its next emission while the input stays not ready.
// Reset (synchronous, active low) empties the stack, clears both flags and
// the output valid; stack RAM contents and output data are not cleared.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    itp_in_if.sink    i_in,
    itp_out_if.source o_out
);
    import itp_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_EV   = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic r_ovf, n_ovf, r_unf, n_unf;
    logic r_cmd, n_cmd;
    logic [CHAR_W-1:0] r_chr, n_chr;
    logic r_pv, n_pv;
    logic [CHAR_W-1:0] r_pch, n_pch;

    logic r_ov;
    logic [CHAR_W-1:0] r_o_char;
    logic r_o_end, r_o_ovf, r_o_unf, r_o_last;

    logic emit_v, emit_end, emit_ovf, emit_unf, emit_last;
    logic [CHAR_W-1:0] emit_char;

    logic we, re;
    logic [AW-1:0] waddr, raddr;
    logic [CHAR_W-1:0] wdata, rdata;

    logic out_free, accept, pop, full;
    logic [CW-1:0] cnt_m1;

    assign out_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign accept = i_in.valid && i_in.ready;
    assign full = (r_cnt == FULL);
    assign cnt_m1 = r_cnt - 1'b1;
    assign raddr = cnt_m1[AW-1:0];

    always_comb begin
        if (r_cnt == '0) begin
            pop = 1'b0;
        end else if (r_cmd == CMD_END) begin
            pop = 1'b1;
        end else if (r_chr == CH_CLOSE) begin
            pop = (rdata != CH_OPEN);
        end else begin
            pop = (prec_of(r_chr) <= prec_of(rdata));
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        n_unf   = r_unf;
        n_cmd   = r_cmd;
        n_chr   = r_chr;
        n_pv    = r_pv;
        n_pch   = r_pch;
        emit_v    = 1'b0;
        emit_char = r_pch;
        emit_end  = 1'b0;
        emit_ovf  = 1'b0;
        emit_unf  = 1'b0;
        emit_last = 1'b0;
        we    = 1'b0;
        waddr = r_cnt[AW-1:0];
        wdata = r_chr;
        re    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd = i_in.command;
                    n_chr = i_in.character;
                    if (i_in.command == CMD_END) begin
                        n_state = S_RD;
                    end else if (is_alnum(i_in.character)) begin
                        n_pv    = 1'b1;
                        n_pch   = i_in.character;
                        n_state = S_FIN;
                    end else if (i_in.character == CH_OPEN) begin
                        if (full) begin
                            n_ovf = 1'b1;
                        end else begin
                            we    = 1'b1;
                            wdata = i_in.character;
                            n_cnt = r_cnt + 1'b1;
                        end
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                re      = (r_cnt != '0);
                n_state = S_EV;
            end
            S_EV: begin
                if (pop) begin
                    if (!(r_pv && !out_free)) begin
                        emit_v  = r_pv;
                        n_pv    = 1'b1;
                        n_pch   = rdata;
                        n_cnt   = cnt_m1;
                        n_state = S_RD;
                    end
                end else begin
                    if (r_cmd == CMD_CHAR) begin
                        if (r_chr == CH_CLOSE) begin
                            if (r_cnt != '0) begin
                                n_cnt = cnt_m1;
                            end else begin
                                n_unf = 1'b1;
                            end
                        end else if (full) begin
                            n_ovf = 1'b1;
                        end else begin
                            we    = 1'b1;
                            n_cnt = r_cnt + 1'b1;
                        end
                    end
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    if (r_pv) begin
                        emit_v    = 1'b1;
                        emit_last = (r_cmd == CMD_CHAR);
                        n_pv      = 1'b0;
                        if (r_cmd == CMD_CHAR) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        if (r_cmd == CMD_END) begin
                            emit_v    = 1'b1;
                            emit_char = '0;
                            emit_end  = 1'b1;
                            emit_ovf  = r_ovf;
                            emit_unf  = r_unf;
                            emit_last = 1'b1;
                            n_ovf     = 1'b0;
                            n_unf     = 1'b0;
                        end
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_unf   <= 1'b0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_unf   <= n_unf;
            r_pv    <= n_pv;
            if (emit_v) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_chr <= n_chr;
        r_pch <= n_pch;
        if (emit_v) begin
            r_o_char <= emit_char;
            r_o_end  <= emit_end;
            r_o_ovf  <= emit_ovf;
            r_o_unf  <= emit_unf;
            r_o_last <= emit_last;
        end
    end

    assign o_out.valid           = r_ov;
    assign o_out.out_char        = r_o_char;
    assign o_out.end_marker      = r_o_end;
    assign o_out.overflowed      = r_o_ovf;
    assign o_out.unmatched_close = r_o_unf;
    assign o_out.last            = r_o_last;

    itp_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );
endmodule

### rtl/itp_checker.sv
// Port-level assertions for the converter, bound to the top level.
module itp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_command,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_end,
    input logic       i_out_ovf,
    input logic       i_out_unf,
    input logic       i_out_last
);
    import itp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char)
            && $stable(i_out_end) && $stable(i_out_last))
        else $error("result word changed while stalled");

    a_flags_only_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_end |-> !i_out_ovf && !i_out_unf)
        else $error("error flag on a non-terminator word");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_end |-> i_out_last && (i_out_char == 8'h00))
        else $error("terminator word malformed");

    a_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_command == CMD_END) |=> !i_in_ready)
        else $error("input ready right after an end command");
endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_command (i_in.command),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_char   (o_out.out_char),
    .i_out_end    (o_out.end_marker),
    .i_out_ovf    (o_out.overflowed),
    .i_out_unf    (o_out.unmatched_close),
    .i_out_last   (o_out.last)
);
